### src/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, sizes and codes for the max tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int PORT_WIDTH  = 32;
  localparam int COUNT_WIDTH = 9;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic        [PTR_W-1:0]       ptr_t;
  typedef logic        [ADDR_W-1:0]      addr_t;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

endpackage

`default_nettype wire

### src/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/max_tracking_stack.sv
// ----------------------------------------------------------------------------
// max_tracking_stack
// LIFO of signed words that also reports its running maximum.
// A push or a rejected op gives its result in the cycle after start; a pop
// first enters S_POP_WAIT for the RAM read of the new tops, then gives its result.
// One push per cycle while not busy; a pop holds busy during S_POP_WAIT.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Synchronous reset empties both stacks; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module max_tracking_stack (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              action,
  input  wire logic signed [mts_pkg::PORT_WIDTH-1:0] push_value,
  output logic                                   done,
  output logic signed [mts_pkg::PORT_WIDTH-1:0]  popped_value,
  output logic signed [mts_pkg::PORT_WIDTH-1:0]  current_max,
  output logic                                   is_empty,
  output logic        [mts_pkg::COUNT_WIDTH-1:0] fill_count,
  output logic        [1:0]                      status
);

  import mts_pkg::*;

  localparam logic S_IDLE     = 1'b0;
  localparam logic S_POP_WAIT = 1'b1;

  logic   state;
  ptr_t   dp;
  ptr_t   mp;
  value_t data_top;
  value_t max_top;
  logic   pend_max_pop;

  value_t push_v;
  logic   accept;
  logic   full;
  logic   empty;
  logic   take_max;
  logic   max_pop;
  logic   data_we;
  logic   max_we;
  addr_t  data_raddr;
  addr_t  max_raddr;
  value_t data_rd;
  value_t max_rd;
  value_t new_max;
  value_t pop_max;

  assign busy       = (state == S_POP_WAIT);
  assign accept     = start && !busy;
  assign push_v     = value_t'(push_value);
  assign full       = (dp == ptr_t'(STACK_DEPTH));
  assign empty      = (dp == '0);
  assign take_max   = (mp == '0) || (push_v >= max_top);
  assign max_pop    = (mp != '0) && (max_top == data_top);
  assign data_we    = accept && (action == ACT_PUSH) && !full;
  assign max_we     = data_we && take_max;
  assign data_raddr = addr_t'(dp - ptr_t'(2));
  assign max_raddr  = addr_t'(mp - ptr_t'(2));
  assign new_max    = take_max ? push_v : max_top;
  assign pop_max    = pend_max_pop ? max_rd : max_top;

  mts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (addr_t'(dp)),
    .wdata (push_v),
    .raddr (data_raddr),
    .rdata (data_rd)
  );

  mts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (addr_t'(mp)),
    .wdata (push_v),
    .raddr (max_raddr),
    .rdata (max_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dp    <= '0;
      mp    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == ACT_PUSH) begin
              done         <= 1'b1;
              popped_value <= '0;
              fill_count   <= COUNT_WIDTH'(dp);
              is_empty     <= empty;
              current_max  <= empty ? '0 : PORT_WIDTH'(max_top);
              status       <= ST_PUSH_FULL;
              if (!full) begin
                dp          <= dp + ptr_t'(1);
                data_top    <= push_v;
                fill_count  <= COUNT_WIDTH'(dp + ptr_t'(1));
                is_empty    <= 1'b0;
                current_max <= PORT_WIDTH'(new_max);
                status      <= ST_OK;
                if (take_max) begin
                  mp      <= mp + ptr_t'(1);
                  max_top <= push_v;
                end
              end
            end else if (empty) begin
              done         <= 1'b1;
              popped_value <= '0;
              fill_count   <= COUNT_WIDTH'(dp);
              is_empty     <= 1'b1;
              current_max  <= '0;
              status       <= ST_POP_EMPTY;
            end else begin
              state        <= S_POP_WAIT;
              popped_value <= PORT_WIDTH'(data_top);
              dp           <= dp - ptr_t'(1);
              pend_max_pop <= max_pop;
              if (max_pop) begin
                mp <= mp - ptr_t'(1);
              end
            end
          end
        end
        S_POP_WAIT: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          data_top    <= data_rd;
          max_top     <= pop_max;
          fill_count  <= COUNT_WIDTH'(dp);
          is_empty    <= empty;
          current_max <= empty ? '0 : PORT_WIDTH'(pop_max);
          status      <= ST_OK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pop_wait_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("pop wait lasted more than one cycle");

  a_pop_wait_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("pop completed without a result");

  a_max_le_data: assert property (@(posedge clk) disable iff (rst)
    mp <= dp)
    else $error("max stack deeper than data stack");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_PUSH)) |=> (done && !is_empty))
    else $error("push gave no result or left the stack empty");

  a_data_max_nonempty: assert property (@(posedge clk) disable iff (rst)
    (dp != '0) |-> (mp != '0))
    else $error("data held with an empty max stack");

endmodule

`default_nettype wire
